FILE: rtl/int2dec_pkg.sv
// Shared constants and types for the binary to decimal ASCII converter.
package int2dec_pkg;

  // Width of the value_bits field on the input channel.
  localparam int FIELD_WIDTH = 64;
  // Bits of value_bits that take part in the conversion (8 to 64).
  localparam int VALUE_WIDTH = 64;
  // Decimal digits needed for the largest unsigned value: ceil(W * log10(2)).
  localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103 + 99999) / 100000;

  localparam int CNT_W = $clog2(VALUE_WIDTH);
  localparam int REM_W = $clog2(NUM_DIGITS);

  localparam logic [7:0] ASCII_ZERO  = 8'h30;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;
  localparam logic [3:0] DIGIT_MAX   = 4'd9;
  localparam logic [3:0] DABBLE_MIN  = 4'd5;
  localparam logic [3:0] DABBLE_ADD  = 4'd3;

  // Per-cycle command broadcast to every digit cell.
  typedef struct packed {
    logic clr;     // clear digit to zero
    logic dabble;  // add-3 correction and shift one binary bit in
    logic move;    // take the digit of the next lower cell
  } cell_ctrl_t;

endpackage

FILE: rtl/int2dec_if.sv
// Valid/ready channel interfaces for the converter input and output.
interface int2dec_in_if;
  logic                                valid;
  logic                                ready;
  logic [int2dec_pkg::FIELD_WIDTH-1:0] value_bits;
  logic                                signed_mode;

  modport source (output valid, output value_bits, output signed_mode, input ready);
  modport sink   (input valid, input value_bits, input signed_mode, output ready);
endinterface

interface int2dec_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] ascii_char;
  logic       last_char;

  modport source (output valid, output ascii_char, output last_char, input ready);
  modport sink   (input valid, input ascii_char, input last_char, output ready);
endinterface

FILE: rtl/int2dec_cell.sv
// One BCD digit cell of the shift-add-3 converter chain.
module int2dec_cell (
  input  logic                    clk_i,
  input  int2dec_pkg::cell_ctrl_t ctrl_i,
  input  logic                    carry_i,
  input  logic [3:0]              digit_i,
  output logic                    carry_o,
  output logic [3:0]              digit_o
);

  logic [3:0] digit_q;
  logic [3:0] digit_d;
  logic [3:0] adj;

  assign adj = (digit_q >= int2dec_pkg::DABBLE_MIN) ? digit_q + int2dec_pkg::DABBLE_ADD
                                                     : digit_q;

  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clr) begin
      digit_d = '0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], carry_i};
    end else if (ctrl_i.move) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign carry_o = adj[3];
  assign digit_o = digit_q;

endmodule

FILE: rtl/int_to_decimal_ascii.sv
// Top level: binary to decimal ASCII converter built on a row of BCD digit cells.
//
// Usage:
//   in_i  : one transaction per number (value_bits, signed_mode). Only the low
//           VALUE_WIDTH bits of value_bits are used. in_i.ready is high only
//           while the converter is idle, so one number is in work at a time.
//   out_o : one transaction per character, most significant first. A negative
//           signed number starts with '-'. No leading zeros; zero gives '0'.
//           last_char marks the final character of the number.
// Timing:
//   After acceptance the digit row runs VALUE_WIDTH shift-add-3 steps, then
//   drops leading zeros at one digit per cycle (up to NUM_DIGITS-1 = 19
//   digits), then emits one character per cycle while the sink takes them.
// Stalls: characters leave through one output register; while out_o.ready is
//   low the character is held and the digit row waits. in_i.ready comes back
//   as soon as the last character sits in the output register.
// Reset: rst_ni (async, active low) returns the control to idle and drops
//   out_o.valid. The digit cells need no reset; they clear on every accepted
//   number.
module int_to_decimal_ascii (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  int2dec_in_if.sink           in_i,
  int2dec_out_if.source        out_o
);

  localparam int W  = int2dec_pkg::VALUE_WIDTH;
  localparam int ND = int2dec_pkg::NUM_DIGITS;

  // Sequencer codes
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CONV = 3'd1;
  localparam logic [2:0] ST_SKIP = 3'd2;
  localparam logic [2:0] ST_SIGN = 3'd3;
  localparam logic [2:0] ST_EMIT = 3'd4;

  logic [2:0]                    state_q, state_d;
  logic [W-1:0]                  bin_q, bin_d;
  logic                          neg_q, neg_d;
  logic [int2dec_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [int2dec_pkg::REM_W-1:0] rem_q, rem_d;

  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    char_q, char_d;
  logic                          last_q, last_d;

  logic                          in_fire;
  logic                          slot_free;
  logic                          load_out;
  logic [W-1:0]                  in_val;
  logic                          in_neg;
  logic [W-1:0]                  in_mag;
  logic                          skip;

  int2dec_pkg::cell_ctrl_t       cell_ctrl;
  logic [ND:0]                   carry;
  logic [3:0]                    digit [ND];
  logic [3:0]                    top_digit;

  // ---------------------------------------------------------------------------
  // Input side: sign handling. Negating the most negative value wraps to
  // 2^(W-1), which is its true magnitude as an unsigned W-bit number.
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == ST_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign in_val     = in_i.value_bits[W-1:0];
  assign in_neg     = in_i.signed_mode && in_val[W-1];
  assign in_mag     = in_neg ? (~in_val + W'(1)) : in_val;

  // ---------------------------------------------------------------------------
  // Digit row. Cell 0 is the least significant digit; binary bits enter there
  // MSB first. During output, digits shift up so the top cell always holds the
  // next character.
  // ---------------------------------------------------------------------------
  assign carry[0] = bin_q[W-1];

  for (genvar g = 0; g < ND; g++) begin : g_cell
    logic [3:0] lower_digit;
    if (g == 0) begin : g_first
      assign lower_digit = '0;
    end else begin : g_rest
      assign lower_digit = digit[g-1];
    end

    int2dec_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .carry_i (carry[g]),
      .digit_i (lower_digit),
      .carry_o (carry[g+1]),
      .digit_o (digit[g])
    );
  end

  assign top_digit = digit[ND-1];

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  assign slot_free = !out_valid_q || out_o.ready;
  assign skip      = (top_digit == 4'd0) && (rem_q != '0);

  always_comb begin
    state_d        = state_q;
    bin_d          = bin_q;
    neg_d          = neg_q;
    cnt_d          = cnt_q;
    rem_d          = rem_q;
    load_out       = 1'b0;
    char_d         = char_q;
    last_d         = last_q;
    cell_ctrl      = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          bin_d         = in_mag;
          neg_d         = in_neg;
          cnt_d         = '0;
          cell_ctrl.clr = 1'b1;
          state_d       = ST_CONV;
        end
      end
      ST_CONV: begin
        cell_ctrl.dabble = 1'b1;
        bin_d            = {bin_q[W-2:0], 1'b0};
        cnt_d            = cnt_q + 1'b1;
        if (cnt_q == int2dec_pkg::CNT_W'(W - 1)) begin
          rem_d   = int2dec_pkg::REM_W'(ND - 1);
          state_d = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop leading zeros, always keep at least one digit
        if (skip) begin
          cell_ctrl.move = 1'b1;
          rem_d          = rem_q - 1'b1;
        end else begin
          state_d = neg_q ? ST_SIGN : ST_EMIT;
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          load_out = 1'b1;
          char_d   = int2dec_pkg::ASCII_MINUS;
          last_d   = 1'b0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          char_d   = int2dec_pkg::ASCII_ZERO + {4'd0, top_digit};
          last_d   = (rem_q == '0);
          if (rem_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            cell_ctrl.move = 1'b1;
            rem_d          = rem_q - 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q  <= bin_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    rem_q  <= rem_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.ascii_char = char_q;
  assign out_o.last_char  = last_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------

  // The digit row is sized for the widest value: the top cell never overflows.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CONV) |-> !carry[ND])
    else $error("digit row overflow during conversion");

  // Every character shown is a digit or the minus sign.
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((char_q == int2dec_pkg::ASCII_MINUS) ||
                     ((char_q >= int2dec_pkg::ASCII_ZERO) &&
                      (char_q <= int2dec_pkg::ASCII_ZERO + {4'd0, int2dec_pkg::DIGIT_MAX}))))
    else $error("illegal output character");

  // The sign never ends a number.
  a_sign_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (char_q == int2dec_pkg::ASCII_MINUS)) |-> !last_q)
    else $error("minus sign flagged as last character");

  // A stalled character is not overwritten.
  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(char_q) && $stable(last_q)))
    else $error("output character changed under stall");

endmodule
